[rtl/sls_pkg.sv]
// Shared types, codes and field widths of the sequential list store.
package sls_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 4;
  localparam int COUNT_W  = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND  = 3'd0,
    ACT_PREPEND = 3'd1,
    ACT_REMOVE  = 3'd2,
    ACT_SEARCH  = 3'd3,
    ACT_READ    = 3'd4,
    ACT_CLEAR   = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_MISSING = 2'd2,
    STS_RANGE   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RDWAIT,
    ST_RESP
  } state_t;

endpackage

[rtl/sls_if.sv]
// Valid/ready channel interfaces for the request and result beats.
interface sls_in_if;
  logic                                valid;
  logic                                ready;
  logic [sls_pkg::ACTION_W-1:0]        action;
  logic signed [sls_pkg::VALUE_W-1:0]  value;
  logic [sls_pkg::INDEX_W-1:0]         index;

  modport source (output valid, action, value, index, input ready);
  modport sink   (input valid, action, value, index, output ready);
endinterface

interface sls_out_if;
  logic                                valid;
  logic                                ready;
  logic [sls_pkg::STATUS_W-1:0]        status;
  logic [sls_pkg::FOUND_W-1:0]         found_index;
  logic signed [sls_pkg::VALUE_W-1:0]  read_data;
  logic [sls_pkg::COUNT_W-1:0]         count;

  modport source (output valid, status, found_index, read_data, count, input ready);
  modport sink   (input valid, status, found_index, read_data, count, output ready);
endinterface

[rtl/sls_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module sls_ram #(
  parameter int WIDTH = sls_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = sls_pkg::CAPACITY_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/sequential_list_store.sv]
// Top level of the sequential list store: sequencer, fill count and result register.
//
//   channel | dir | beat contents
//   --------+-----+------------------------------------------
//   in_ch   | in  | action, value, index
//   out_ch  | out | status, found_index, read_data, count
//
// Append, clear, the unused codes and requests that fail at once go straight to the response
// state; an in-range read passes the read wait state first. Prepend shifts entries up and
// writes entry 0, search scans to a match or the end, remove scans and shifts later entries
// down, all via the single read port of the entry RAM. One request is in flight at a time;
// a new one is taken while a finished result still waits on out_ch. Reset empties the list.
module sequential_list_store #(
  parameter int CAPACITY   = sls_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = sls_pkg::DATA_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  sls_in_if.sink   in_ch,
  sls_out_if.source out_ch
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > sls_pkg::INDEX_W) ? CW : sls_pkg::INDEX_W;

  sls_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]                      cnt_r, cnt_nxt;
  logic [sls_pkg::ACTION_W-1:0]       act_r, act_nxt;
  logic [DATA_WIDTH-1:0]              val_r, val_nxt;
  logic [AW-1:0]                      src_r, src_nxt;
  logic [AW-1:0]                      dst_r, dst_nxt;
  logic [CW-1:0]                      moves_r, moves_nxt;
  logic                               pend_r, pend_nxt;
  logic [AW-1:0]                      pend_dst_r, pend_dst_nxt;
  logic [CW-1:0]                      scan_r, scan_nxt;
  logic                               cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]                      cmp_idx_r, cmp_idx_nxt;
  logic [sls_pkg::STATUS_W-1:0]       res_status_r, res_status_nxt;
  logic [sls_pkg::FOUND_W-1:0]        res_found_r, res_found_nxt;
  logic signed [sls_pkg::VALUE_W-1:0] res_data_r, res_data_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [sls_pkg::STATUS_W-1:0]       out_status_r;
  logic [sls_pkg::FOUND_W-1:0]        out_found_r;
  logic signed [sls_pkg::VALUE_W-1:0] out_data_r;
  logic [sls_pkg::COUNT_W-1:0]        out_count_r;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  in_range;
  logic [DATA_WIDTH-1:0] in_val;
  logic                  match;
  logic                  scan_issue;
  logic                  scan_done;
  logic                  shift_end;
  logic                  out_load;

  sls_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == sls_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (cnt_r >= CW'(CAPACITY));
  assign empty       = (cnt_r == '0);
  assign in_range    = (CMPW'(in_ch.index) < CMPW'(cnt_r));
  assign in_val      = DATA_WIDTH'($unsigned(in_ch.value));
  assign match       = cmp_vld_r && (ram_rdata == val_r);
  assign scan_issue  = (scan_r < cnt_r);
  assign scan_done   = !scan_issue && !cmp_vld_r;
  assign shift_end   = !pend_r && (moves_r == '0);
  assign out_load    = (state_r == sls_pkg::ST_RESP) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sls_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_ch.action) inside
            sls_pkg::ACT_PREPEND: begin
              state_nxt = (full || empty) ? sls_pkg::ST_RESP : sls_pkg::ST_SHIFT;
            end
            sls_pkg::ACT_REMOVE, sls_pkg::ACT_SEARCH: begin
              state_nxt = empty ? sls_pkg::ST_RESP : sls_pkg::ST_SCAN;
            end
            sls_pkg::ACT_READ: begin
              state_nxt = in_range ? sls_pkg::ST_RDWAIT : sls_pkg::ST_RESP;
            end
            default: begin
              state_nxt = sls_pkg::ST_RESP;
            end
          endcase
        end
      end
      sls_pkg::ST_SCAN: begin
        if (match) begin
          state_nxt = (act_r == sls_pkg::ACT_REMOVE) ? sls_pkg::ST_SHIFT : sls_pkg::ST_RESP;
        end else if (scan_done) begin
          state_nxt = sls_pkg::ST_RESP;
        end
      end
      sls_pkg::ST_SHIFT: begin
        if (shift_end) begin
          state_nxt = sls_pkg::ST_RESP;
        end
      end
      sls_pkg::ST_RDWAIT: begin
        state_nxt = sls_pkg::ST_RESP;
      end
      sls_pkg::ST_RESP: begin
        if (out_load) begin
          state_nxt = sls_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sls_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    act_nxt        = act_r;
    val_nxt        = val_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    moves_nxt      = moves_r;
    pend_nxt       = pend_r;
    pend_dst_nxt   = pend_dst_r;
    scan_nxt       = scan_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_data_nxt   = res_data_r;
    ram_we         = 1'b0;
    ram_waddr      = pend_dst_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = src_r;
    unique case (state_r)
      sls_pkg::ST_IDLE: begin
        ram_raddr = AW'(in_ch.index);
        if (accept) begin
          act_nxt        = in_ch.action;
          val_nxt        = in_val;
          res_status_nxt = sls_pkg::STS_OK;
          res_found_nxt  = '0;
          res_data_nxt   = '0;
          unique case (in_ch.action) inside
            sls_pkg::ACT_APPEND: begin
              if (full) begin
                res_status_nxt = sls_pkg::STS_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(cnt_r);
                ram_wdata = in_val;
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
            sls_pkg::ACT_PREPEND: begin
              if (full) begin
                res_status_nxt = sls_pkg::STS_FULL;
              end else if (empty) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = in_val;
                cnt_nxt   = cnt_r + CW'(1);
              end else begin
                src_nxt   = AW'(cnt_r - CW'(1));
                dst_nxt   = AW'(cnt_r);
                moves_nxt = cnt_r;
                pend_nxt  = 1'b0;
              end
            end
            sls_pkg::ACT_REMOVE, sls_pkg::ACT_SEARCH: begin
              if (empty) begin
                res_status_nxt = sls_pkg::STS_MISSING;
              end else begin
                scan_nxt    = '0;
                cmp_vld_nxt = 1'b0;
              end
            end
            sls_pkg::ACT_READ: begin
              if (!in_range) begin
                res_status_nxt = sls_pkg::STS_RANGE;
              end
            end
            sls_pkg::ACT_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      sls_pkg::ST_SCAN: begin
        ram_raddr = AW'(scan_r);
        if (scan_issue) begin
          scan_nxt    = scan_r + CW'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = AW'(scan_r);
        end else begin
          cmp_vld_nxt = 1'b0;
        end
        if (match) begin
          cmp_vld_nxt = 1'b0;
          if (act_r == sls_pkg::ACT_REMOVE) begin
            dst_nxt   = cmp_idx_r;
            src_nxt   = cmp_idx_r + AW'(1);
            moves_nxt = cnt_r - CW'(1) - CW'(cmp_idx_r);
            pend_nxt  = 1'b0;
          end else begin
            res_found_nxt = sls_pkg::FOUND_W'(cmp_idx_r);
          end
        end else if (scan_done) begin
          res_status_nxt = sls_pkg::STS_MISSING;
        end
      end
      sls_pkg::ST_SHIFT: begin
        if (moves_r != '0) begin
          moves_nxt    = moves_r - CW'(1);
          pend_nxt     = 1'b1;
          pend_dst_nxt = dst_r;
          if (act_r == sls_pkg::ACT_PREPEND) begin
            src_nxt = src_r - AW'(1);
            dst_nxt = dst_r - AW'(1);
          end else begin
            src_nxt = src_r + AW'(1);
            dst_nxt = dst_r + AW'(1);
          end
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          ram_we = 1'b1;
        end else if (moves_r == '0) begin
          if (act_r == sls_pkg::ACT_PREPEND) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = val_r;
            cnt_nxt   = cnt_r + CW'(1);
          end else begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end
      end
      sls_pkg::ST_RDWAIT: begin
        res_data_nxt = sls_pkg::VALUE_W'($signed(ram_rdata));
      end
      sls_pkg::ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sls_pkg::ST_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    val_r        <= val_nxt;
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    moves_r      <= moves_nxt;
    pend_dst_r   <= pend_dst_nxt;
    scan_r       <= scan_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_data_r   <= res_data_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_data_r   <= res_data_r;
      out_count_r  <= sls_pkg::COUNT_W'(cnt_r);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_index = out_found_r;
  assign out_ch.read_data   = out_data_r;
  assign out_ch.count       = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("Fill count exceeds the capacity.");

  a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sls_pkg::ST_SHIFT && pend_r && moves_r != '0) |-> ram_waddr != ram_raddr)
    else $error("Shift reads and writes the same entry in one cycle.");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == sls_pkg::ST_RESP)
    else $error("Result beat raised outside the response state.");

  a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.action == sls_pkg::ACT_APPEND && !full) |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("Append did not advance the fill count.");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.action == sls_pkg::ACT_CLEAR) |=> cnt_r == '0)
    else $error("Clear left entries in the list.");

endmodule
